// File: sv/line_scrollback_buffer_top_assert.svh
`ifndef LINE_SCROLLBACK_BUFFER_TOP_ASSERT_SVH
`define LINE_SCROLLBACK_BUFFER_TOP_ASSERT_SVH

// Check that holds at every edge out of reset.
`define LSB_ASSERT_ALWAYS(name, clk, rst_n, cond, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check that holds in the same cycle as the trigger.
`define LSB_ASSERT_IMPLIES(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that holds in the cycle after the trigger.
`define LSB_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/lsb_pkg.sv
`timescale 1ns / 1ps

package lsb_pkg;

    localparam int LINES_DEF    = 32;
    localparam int LINE_LEN_DEF = 128;
    localparam int BYTE_W       = 8;
    localparam int LEN_W        = 8;

    localparam logic [BYTE_W-1:0] NEWLINE_BYTE = 8'h0A;

    typedef enum logic {
        OP_APPEND = 1'b0,
        OP_READ   = 1'b1
    } t_op;

    typedef struct packed {
        logic              cmd;
        logic [BYTE_W-1:0] in_byte;
    } t_in_word;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              end_of_history;
        logic              history_empty;
    } t_out_word;

    typedef struct packed {
        t_op               op;
        logic              newline;
        logic [BYTE_W-1:0] data;
    } t_cmd_word;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEEK,
        ST_FETCH,
        ST_SCAN,
        ST_EMIT
    } t_back_state;

endpackage

// File: sv/lsb_ram.sv
`timescale 1ns / 1ps

module lsb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: sv/lsb_front.sv
`timescale 1ns / 1ps

module lsb_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  lsb_pkg::t_in_word    i_in_word,
    output logic                 o_q_valid,
    input  logic                 i_q_pop,
    output lsb_pkg::t_cmd_word   o_q_word
);

    lsb_pkg::t_cmd_word r_q [2];
    logic               r_wptr;
    logic               r_rptr;
    logic [1:0]         r_count;
    lsb_pkg::t_cmd_word n_word;
    logic               push;
    logic               pop;

    always_comb begin
        n_word.op      = i_in_word.cmd ? lsb_pkg::OP_READ : lsb_pkg::OP_APPEND;
        n_word.newline = (i_in_word.in_byte == lsb_pkg::NEWLINE_BYTE);
        n_word.data    = i_in_word.in_byte;
    end

    assign o_in_ready = (r_count != 2'd2);
    assign o_q_valid  = (r_count != 2'd0);
    assign o_q_word   = r_q[r_rptr];
    assign push       = i_in_valid && o_in_ready;
    assign pop        = i_q_pop && o_q_valid;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wptr] <= n_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (push) begin
                r_wptr <= ~r_wptr;
            end
            if (pop) begin
                r_rptr <= ~r_rptr;
            end
            case ({push, pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// File: sv/lsb_back.sv
`timescale 1ns / 1ps
`include "line_scrollback_buffer_top_assert.svh"

module lsb_back #(
    parameter int LINES    = lsb_pkg::LINES_DEF,
    parameter int LINE_LEN = lsb_pkg::LINE_LEN_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_q_valid,
    output logic                 o_q_pop,
    input  lsb_pkg::t_cmd_word   i_q_word,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output lsb_pkg::t_out_word   o_out_word
);

    localparam int SLOT_W = (LINES > 1) ? $clog2(LINES) : 1;
    localparam int VIS_W  = $clog2(LINES + 1);
    localparam int DEPTH  = LINES * LINE_LEN;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int LEN_W  = lsb_pkg::LEN_W;

    localparam logic [LEN_W-1:0]  LINE_LEN_L  = LEN_W'(LINE_LEN);
    localparam logic [ADDR_W-1:0] LINE_STEP   = ADDR_W'(LINE_LEN);
    localparam logic [SLOT_W-1:0] LAST_SLOT   = SLOT_W'(LINES - 1);
    localparam logic [VIS_W-1:0]  VISIT_LIMIT = VIS_W'(LINES);

    lsb_pkg::t_back_state r_state, n_state;
    logic [SLOT_W-1:0]    r_wr_slot, n_wr_slot;
    logic [LEN_W-1:0]     r_wr_pos, n_wr_pos;
    logic [ADDR_W-1:0]    r_wr_base, n_wr_base;
    logic [SLOT_W-1:0]    r_rp_slot, n_rp_slot;
    logic [LEN_W-1:0]     r_rp_pos, n_rp_pos;
    logic [ADDR_W-1:0]    r_rp_base, n_rp_base;
    logic [VIS_W-1:0]     r_rp_visited, n_rp_visited;
    logic                 r_rp_active, n_rp_active;
    logic [LEN_W-1:0]     r_len [LINES];
    lsb_pkg::t_out_word   r_res, n_res;
    logic                 r_out_valid, n_out_valid;
    lsb_pkg::t_out_word   r_out_word, n_out_word;

    logic                 len_we;
    logic [LEN_W-1:0]     len_wdata;
    logic                 ram_we;
    logic [ADDR_W-1:0]    ram_waddr;
    logic [ADDR_W-1:0]    ram_raddr;
    logic [7:0]           ram_rdata;

    logic [LEN_W-1:0]     cur_len;
    logic                 pass_done;
    logic                 has_byte;
    logic                 rp_last_slot;
    logic                 wr_last_slot;
    logic [LEN_W-1:0]     wr_pos_inc;
    logic                 out_free;

    lsb_ram #(
        .WIDTH (lsb_pkg::BYTE_W),
        .DEPTH (DEPTH)
    ) u_line_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (i_q_word.data),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign cur_len      = (r_rp_slot == r_wr_slot) ? r_wr_pos : r_len[r_rp_slot];
    assign pass_done    = (r_rp_visited == VISIT_LIMIT);
    assign has_byte     = (r_rp_pos < cur_len);
    assign rp_last_slot = (r_rp_slot == LAST_SLOT);
    assign wr_last_slot = (r_wr_slot == LAST_SLOT);
    assign wr_pos_inc   = r_wr_pos + LEN_W'(1);
    assign out_free     = !r_out_valid || i_out_ready;
    assign ram_waddr    = r_wr_base + ADDR_W'(r_wr_pos);
    assign ram_raddr    = r_rp_base + ADDR_W'(r_rp_pos);

    always_comb begin
        n_state      = r_state;
        n_wr_slot    = r_wr_slot;
        n_wr_pos     = r_wr_pos;
        n_wr_base    = r_wr_base;
        n_rp_slot    = r_rp_slot;
        n_rp_pos     = r_rp_pos;
        n_rp_base    = r_rp_base;
        n_rp_visited = r_rp_visited;
        n_rp_active  = r_rp_active;
        n_res        = r_res;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_out_word   = r_out_word;
        len_we       = 1'b0;
        len_wdata    = wr_pos_inc;
        ram_we       = 1'b0;
        o_q_pop      = 1'b0;

        case (r_state)
            lsb_pkg::ST_IDLE: begin
                o_q_pop = i_q_valid;
                if (i_q_valid) begin
                    if (i_q_word.op == lsb_pkg::OP_APPEND) begin
                        ram_we      = 1'b1;
                        n_rp_active = 1'b0;
                        if (i_q_word.newline || wr_pos_inc == LINE_LEN_L) begin
                            len_we    = 1'b1;
                            n_wr_pos  = '0;
                            n_wr_slot = wr_last_slot ? '0 : r_wr_slot + SLOT_W'(1);
                            n_wr_base = wr_last_slot ? '0 : r_wr_base + LINE_STEP;
                        end else begin
                            n_wr_pos = wr_pos_inc;
                        end
                    end else begin
                        if (!r_rp_active) begin
                            n_rp_slot    = wr_last_slot ? '0 : r_wr_slot + SLOT_W'(1);
                            n_rp_base    = wr_last_slot ? '0 : r_wr_base + LINE_STEP;
                            n_rp_pos     = '0;
                            n_rp_visited = '0;
                            n_rp_active  = 1'b1;
                        end
                        n_state = lsb_pkg::ST_SEEK;
                    end
                end
            end
            lsb_pkg::ST_SEEK: begin
                if (pass_done) begin
                    n_res.out_byte       = '0;
                    n_res.end_of_history = 1'b1;
                    n_res.history_empty  = 1'b1;
                    n_rp_active          = 1'b0;
                    n_state              = lsb_pkg::ST_EMIT;
                end else if (has_byte) begin
                    n_state = lsb_pkg::ST_FETCH;
                end else begin
                    n_rp_slot    = rp_last_slot ? '0 : r_rp_slot + SLOT_W'(1);
                    n_rp_base    = rp_last_slot ? '0 : r_rp_base + LINE_STEP;
                    n_rp_pos     = '0;
                    n_rp_visited = r_rp_visited + VIS_W'(1);
                end
            end
            lsb_pkg::ST_FETCH: begin
                n_res.out_byte      = ram_rdata;
                n_res.history_empty = 1'b0;
                n_rp_pos            = r_rp_pos + LEN_W'(1);
                n_state             = lsb_pkg::ST_SCAN;
            end
            lsb_pkg::ST_SCAN: begin
                if (pass_done || has_byte) begin
                    n_res.end_of_history = pass_done;
                    if (pass_done) begin
                        n_rp_active = 1'b0;
                    end
                    if (out_free) begin
                        n_out_valid = 1'b1;
                        n_out_word  = n_res;
                        n_state     = lsb_pkg::ST_IDLE;
                    end else begin
                        n_state = lsb_pkg::ST_EMIT;
                    end
                end else begin
                    n_rp_slot    = rp_last_slot ? '0 : r_rp_slot + SLOT_W'(1);
                    n_rp_base    = rp_last_slot ? '0 : r_rp_base + LINE_STEP;
                    n_rp_pos     = '0;
                    n_rp_visited = r_rp_visited + VIS_W'(1);
                end
            end
            lsb_pkg::ST_EMIT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_word  = r_res;
                    n_state     = lsb_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = lsb_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_res      <= n_res;
        r_out_word <= n_out_word;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= lsb_pkg::ST_IDLE;
            r_wr_slot    <= '0;
            r_wr_pos     <= '0;
            r_wr_base    <= '0;
            r_rp_slot    <= '0;
            r_rp_pos     <= '0;
            r_rp_base    <= '0;
            r_rp_visited <= '0;
            r_rp_active  <= 1'b0;
            r_out_valid  <= 1'b0;
            for (int i = 0; i < LINES; i++) begin
                r_len[i] <= '0;
            end
        end else begin
            r_state      <= n_state;
            r_wr_slot    <= n_wr_slot;
            r_wr_pos     <= n_wr_pos;
            r_wr_base    <= n_wr_base;
            r_rp_slot    <= n_rp_slot;
            r_rp_pos     <= n_rp_pos;
            r_rp_base    <= n_rp_base;
            r_rp_visited <= n_rp_visited;
            r_rp_active  <= n_rp_active;
            r_out_valid  <= n_out_valid;
            if (len_we) begin
                r_len[r_wr_slot] <= len_wdata;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    `LSB_ASSERT_ALWAYS(a_wr_pos_range, i_clk, i_rst_n, r_wr_pos < LINE_LEN_L, "write position reached line length")
    `LSB_ASSERT_ALWAYS(a_visit_range, i_clk, i_rst_n, r_rp_visited <= VISIT_LIMIT, "replay walked past every slot")
    `LSB_ASSERT_IMPLIES(a_empty_is_last, i_clk, i_rst_n, r_out_valid && r_out_word.history_empty, r_out_word.end_of_history, "empty reply not flagged last")
    `LSB_ASSERT_NEXT(a_newline_commit, i_clk, i_rst_n, r_state == lsb_pkg::ST_IDLE && i_q_valid && i_q_word.op == lsb_pkg::OP_APPEND && i_q_word.newline, r_wr_pos == '0 && !r_rp_active, "newline did not close the line")

endmodule

// File: sv/line_scrollback_buffer_top.sv
`timescale 1ns / 1ps

// Console scrollback store: LINES slots of up to LINE_LEN bytes in a ring, kept in
// one line-store RAM. A word with cmd 0 appends a byte; newline or a full line
// closes the line and the oldest slot is reused. A word with cmd 1 returns the next
// history byte, oldest line first, then the open line; end_of_history marks the
// last byte of a pass and history_empty a read with nothing stored. Input words
// enter a two-word queue, so the channel takes up to two words while the engine
// works or the output is stalled. An append is written as it is popped, and the
// engine stays idle for the next word. A read walks slot by slot in SEEK, takes the
// registered RAM read in FETCH and walks on in SCAN to see whether a byte follows;
// an empty history ends in EMIT. A stalled output holds reads, not appends, in EMIT
// until the word is taken. Line lengths reset at once; no clearing pass runs after reset.
module line_scrollback_buffer_top #(
    parameter int LINES    = lsb_pkg::LINES_DEF,
    parameter int LINE_LEN = lsb_pkg::LINE_LEN_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  lsb_pkg::t_in_word    i_in_word,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output lsb_pkg::t_out_word   o_out_word
);

    logic               q_valid;
    logic               q_pop;
    lsb_pkg::t_cmd_word q_word;

    lsb_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_word  (i_in_word),
        .o_q_valid  (q_valid),
        .i_q_pop    (q_pop),
        .o_q_word   (q_word)
    );

    lsb_back #(
        .LINES    (LINES),
        .LINE_LEN (LINE_LEN)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .o_q_pop     (q_pop),
        .i_q_word    (q_word),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word)
    );

endmodule
